### src/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// Types, constants and the default schedule of the actuator sequencer.
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int ACTUATORS  = 8;
    localparam int EV_IW      = $clog2(MAX_EVENTS);
    localparam int ACT_IW     = $clog2(ACTUATORS);
    localparam int CNT_W      = 5;
    localparam int CFG_IW     = 1;
    localparam int CFG_DW     = 8;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;
    localparam logic [1:0] OP_SET    = 2'd3;

    localparam logic [1:0] COND_TIME  = 2'd0;
    localparam logic [1:0] COND_ACCEL = 2'd1;
    localparam logic [1:0] COND_TEMP  = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_EVENTS_IN_USE = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_PWM_MASK      = 1'd1;

    localparam logic [CNT_W-1:0] EVENTS_IN_USE_RST = 5'd4;
    localparam logic [7:0]       PWM_MASK_RST      = 8'd2;
    localparam logic [7:0]       PWM_TOGGLE_LEVEL  = 8'd128;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        time_us;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature;
        logic [3:0]         entry_index;
        logic [2:0]         entry_actuator;
        logic               entry_state;
        logic [7:0]         entry_pwm;
        logic [1:0]         entry_condition;
        logic signed [15:0] entry_threshold;
        logic               entry_greater;
    } req_item_t;

    typedef struct packed {
        logic [2:0] actuator_id;
        logic       actuator_on;
        logic [7:0] pwm_level;
        logic [3:0] event_index;
        logic       from_schedule;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0]        time_us;
        logic [2:0]         act;
        logic               on;
        logic [7:0]         pwm;
        logic [1:0]         cond;
        logic signed [15:0] thr;
        logic               greater;
    } event_entry_t;

    typedef struct packed {
        logic [1:0]         op;
        logic               slot_ok;
        logic [3:0]         slot;
        logic [31:0]        now;
        logic signed [15:0] accel;
        logic signed [15:0] temp;
        event_entry_t       entry;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] act;
        logic       on;
        logic [7:0] level;
        logic [3:0] ev;
        logic       sched;
    } result_t;

    function automatic event_entry_t default_entry(input int idx);
        event_entry_t e;
        e = '0;
        case (idx)
            0: begin
                e.time_us = 32'd5000000;
                e.on      = 1'b1;
            end
            1: begin
                e.time_us = 32'd10000000;
            end
            2: begin
                e.time_us = 32'd15000000;
                e.act     = 3'd1;
                e.on      = 1'b1;
                e.pwm     = 8'd128;
                e.cond    = COND_ACCEL;
                e.thr     = -16'sd2560;
            end
            3: begin
                e.time_us = 32'd20000000;
                e.act     = 3'd1;
                e.on      = 1'b1;
                e.pwm     = 8'd255;
                e.cond    = COND_TEMP;
                e.thr     = 16'sd12800;
                e.greater = 1'b1;
            end
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

### src/cas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_front
// Input register: accepts items and turns them into back-end commands.
// ----------------------------------------------------------------------------
module cas_front import cas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      cmd_valid,
    input  logic      cmd_full,
    output cmd_t      cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic push;

    assign req_stall = valid_reg && cmd_full;
    assign accept    = req_valid && !req_stall;
    assign push      = valid_reg && !cmd_full;

    always_comb
    begin
        cmd_next               = cmd_reg;
        if (accept)
        begin
            cmd_next.op            = req_item.opcode;
            cmd_next.slot          = req_item.entry_index;
            cmd_next.slot_ok       = (int'(req_item.entry_index) < MAX_EVENTS);
            cmd_next.now           = req_item.time_us;
            cmd_next.accel         = req_item.accel_z;
            cmd_next.temp          = req_item.temperature;
            cmd_next.entry.time_us = req_item.time_us;
            cmd_next.entry.act     = req_item.entry_actuator;
            cmd_next.entry.on      = req_item.entry_state;
            cmd_next.entry.pwm     = req_item.entry_pwm;
            cmd_next.entry.cond    = req_item.entry_condition;
            cmd_next.entry.thr     = req_item.entry_threshold;
            cmd_next.entry.greater = req_item.entry_greater;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### src/cas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cas_queue import cas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign avail   = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

### src/cas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_back
// Executor: schedule table, table walk on ticks, actuator state, result output.
// ----------------------------------------------------------------------------
module cas_back import cas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_avail,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_item_t         rsp_item
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [CNT_W-1:0]      eiu_reg;
    logic [7:0]            mask_reg;
    event_entry_t          table_reg [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] fired_reg;
    logic [MAX_EVENTS-1:0] fired_next;
    logic [ACTUATORS-1:0]  on_reg;
    logic [7:0]            lvl_reg [ACTUATORS];
    logic [31:0]           now_reg;
    logic signed [15:0]    accel_reg;
    logic signed [15:0]    temp_reg;
    result_t               pend_reg;
    result_t               pend_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rsp_item_t             out_reg;
    rsp_item_t             out_next;

    logic [CNT_W-1:0]      cnt_lim;
    logic                  in_range;
    event_entry_t          cur;
    logic                  cur_fired;
    logic signed [15:0]    reading;
    logic                  hit;
    logic                  out_free;
    logic                  pend_ok;
    logic                  upd_en;
    logic                  upd_toggle;
    logic [2:0]            upd_act;
    logic                  upd_on;
    logic [7:0]            upd_pwm;
    logic [3:0]            upd_ev;
    logic                  upd_sched;
    logic                  act_ok;
    logic                  act_pwm;
    logic                  new_on;
    logic [7:0]            new_lvl;
    logic [ACT_IW-1:0]     ai;
    logic                  load_en;

    assign cnt_lim   = (eiu_reg > CNT_W'(MAX_EVENTS)) ? CNT_W'(MAX_EVENTS) : eiu_reg;
    assign in_range  = (idx_reg < cnt_lim);
    assign cur       = table_reg[idx_reg[EV_IW-1:0]];
    assign cur_fired = fired_reg[idx_reg[EV_IW-1:0]];
    assign reading   = (cur.cond == COND_ACCEL) ? accel_reg : temp_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign pend_ok   = !pend_reg.valid || out_free;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_avail;
    assign load_en   = cmd_pop && (cmd.op == OP_LOAD) && cmd.slot_ok;

    always_comb
    begin
        case (cur.cond)
            COND_TIME:             hit = (now_reg >= cur.time_us);
            COND_ACCEL, COND_TEMP: hit = cur.greater ? (reading > cur.thr)
                                                     : (reading < cur.thr);
            default:               hit = 1'b0;
        endcase
    end

    // actuator update source: a firing table entry or a direct command
    always_comb
    begin
        upd_en     = 1'b0;
        upd_toggle = 1'b0;
        upd_act    = cmd.entry.act;
        upd_on     = cmd.entry.on;
        upd_pwm    = cmd.entry.pwm;
        upd_ev     = '0;
        upd_sched  = 1'b0;
        if (state_reg == ST_WALK)
        begin
            upd_en    = in_range && !cur_fired && hit && pend_ok;
            upd_act   = cur.act;
            upd_on    = cur.on;
            upd_pwm   = cur.pwm;
            upd_ev    = 4'(idx_reg);
            upd_sched = 1'b1;
        end
        else if (cmd_pop && (cmd.op inside {OP_TOGGLE, OP_SET}))
        begin
            upd_en     = 1'b1;
            upd_toggle = (cmd.op == OP_TOGGLE);
        end
    end

    assign ai      = upd_act[ACT_IW-1:0];
    assign act_ok  = (int'(upd_act) < ACTUATORS);
    assign act_pwm = mask_reg[upd_act];

    always_comb
    begin
        new_on  = on_reg[ai];
        new_lvl = lvl_reg[ai];
        if (act_pwm)
        begin
            if (upd_toggle)
                new_lvl = (lvl_reg[ai] == 8'd0) ? PWM_TOGGLE_LEVEL : 8'd0;
            else
                new_lvl = upd_pwm;
            new_on = (new_lvl != 8'd0);
        end
        else
        begin
            new_on = upd_toggle ? ~on_reg[ai] : upd_on;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fired_next     = fired_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.op)
                        OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_WALK;
                        end
                        OP_LOAD:
                        begin
                            if (cmd.slot_ok)
                                fired_next[cmd.slot[EV_IW-1:0]] = 1'b0;
                        end
                        default:
                        begin
                            pend_next  = '{act_ok, upd_act, new_on, new_lvl, upd_ev, 1'b0};
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!in_range)
                    state_next = ST_FLUSH;
                else if (cur_fired || !hit)
                    idx_next = idx_reg + 1'b1;
                else if (pend_ok)
                begin
                    idx_next                         = idx_reg + 1'b1;
                    fired_next[idx_reg[EV_IW-1:0]]   = 1'b1;
                    if (pend_reg.valid)
                    begin
                        out_next       = '{pend_reg.act, pend_reg.on, pend_reg.level,
                                           pend_reg.ev, pend_reg.sched, 1'b0};
                        out_valid_next = 1'b1;
                    end
                    pend_next = '{act_ok, upd_act, new_on, new_lvl, upd_ev, upd_sched};
                end
            end
            ST_FLUSH:
            begin
                if (!pend_reg.valid)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_next        = '{pend_reg.act, pend_reg.on, pend_reg.level,
                                        pend_reg.ev, pend_reg.sched, 1'b1};
                    out_valid_next  = 1'b1;
                    pend_next.valid = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            fired_reg      <= '0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            eiu_reg        <= EVENTS_IN_USE_RST;
            mask_reg       <= PWM_MASK_RST;
            on_reg         <= '0;
            for (int i = 0; i < ACTUATORS; i++)
                lvl_reg[i] <= 8'd0;
            for (int i = 0; i < MAX_EVENTS; i++)
                table_reg[i] <= default_entry(i);
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            fired_reg      <= fired_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EVENTS_IN_USE: eiu_reg  <= cfg_data[CNT_W-1:0];
                    CFG_PWM_MASK:      mask_reg <= cfg_data;
                    default:           mask_reg <= mask_reg;
                endcase
            end
            if (upd_en && act_ok)
            begin
                on_reg[ai]  <= new_on;
                lvl_reg[ai] <= new_lvl;
            end
            if (load_en)
                table_reg[cmd.slot[EV_IW-1:0]] <= cmd.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        if (cmd_pop && cmd.op == OP_TICK)
        begin
            now_reg   <= cmd.now;
            accel_reg <= cmd.accel;
            temp_reg  <= cmd.temp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_reg.valid)
        else $error("pending result left over in idle");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg <= cnt_lim)
        else $error("table walk ran past the entry count");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH && !pend_reg.valid |=> state_reg == ST_IDLE)
        else $error("flush with nothing pending did not return to idle");

    a_walk_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK && out_valid_next && !(out_valid_reg && rsp_stall)
        |=> !rsp_item.last)
        else $error("result from mid-walk marked last");
`endif

endmodule

### src/conditional_actuator_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conditional_actuator_sequencer_top
// Event sequencer over a one-shot action table driving relay and PWM outputs.
// ----------------------------------------------------------------------------
// channel   signals                          direction
// req       req_valid, req_stall, req_item   items in
// rsp       rsp_valid, rsp_stall, rsp_item   results out
// cfg       cfg_we, cfg_index, cfg_data      register writes
//
// An accepted item passes the input register and the queue on its way to the back end.
// A tick walks min(events_in_use, 16) entries, one per cycle unless the output stalls.
// Load items finish in idle; toggle and set items also pass through the flush state.
// Reset loads the four default schedule entries and clears all outputs.
// A two-entry queue decouples input from execution; rsp_stall holds the walk.
// ----------------------------------------------------------------------------
module conditional_actuator_sequencer_top import cas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_item_t         req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_item_t         rsp_item,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic fr_valid;
    logic q_full;
    cmd_t fr_cmd;
    logic q_pop;
    logic q_avail;
    cmd_t q_head;

    cas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .cmd_valid (fr_valid),
        .cmd_full  (q_full),
        .cmd       (fr_cmd)
    );

    cas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fr_valid),
        .push_cmd (fr_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    cas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (q_avail),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
